[rtl/arp_reply_solicitation_filter_macros.svh]
// Assertion macros shared by the ARP reply filter RTL.
`ifndef ARP_REPLY_SOLICITATION_FILTER_MACROS_SVH
`define ARP_REPLY_SOLICITATION_FILTER_MACROS_SVH

// Generic clocked check with an explicit clock and active-low reset.
`define ARSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the block's own clock and reset.
`define ARSF_CHK(lbl, prop, msg) `ARSF_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/arsf_pkg.sv]
// Package: sizes, codes and types shared by the ARP reply filter.
`default_nettype none

package arsf_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int CELL_ROWS     = 16;
    localparam int ROW_W         = $clog2(CELL_ROWS);
    localparam int NUM_CELLS     = (TABLE_ENTRIES + CELL_ROWS - 1) / CELL_ROWS;
    localparam int CELL_W        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int IDX_W         = CELL_W + ROW_W;
    localparam int FILL_W        = IDX_W + 1;
    localparam int IP_W          = 32;
    localparam int CNT_W         = 32;

    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] OPCODE_REQUEST = 16'd1;
    localparam logic [15:0] OPCODE_REPLY   = 16'd2;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REQUEST,
        OP_REPLY
    } t_op;

    // search token walking down the cell chain, one per table row
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [CNT_W-1:0] hit_count;
    } t_token;

    // table write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [IP_W-1:0]  addr;
        logic [CNT_W-1:0] count;
    } t_write;

    typedef struct packed {
        logic             table_full;
        logic [CNT_W-1:0] count_after;
        logic             tracked;
        logic             drop;
    } t_result;

endpackage

`default_nettype wire

[rtl/arsf_cell.sv]
// One chain cell: a slice of the address table plus its search stage.
`default_nettype none

module arsf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [arsf_pkg::CELL_W-1:0]   i_cell_id,
    input  logic [arsf_pkg::IP_W-1:0]     i_key,
    input  logic [arsf_pkg::FILL_W-1:0]   i_fill,
    input  arsf_pkg::t_write              i_wr,
    input  logic                          i_tok_valid,
    input  arsf_pkg::t_token              i_tok,
    output logic                          o_tok_valid,
    output arsf_pkg::t_token              o_tok
);
    import arsf_pkg::*;

    logic [IP_W-1:0]  r_addr  [CELL_ROWS];
    logic [CNT_W-1:0] r_count [CELL_ROWS];
    logic             r_vld;
    t_token           r_tok;
    t_token           n_tok;
    logic [IDX_W-1:0] w_idx;
    logic             w_match;

    // slot number of this row; slots below the fill mark are in use
    assign w_idx   = {i_cell_id, i_tok.row};
    assign w_match = ({1'b0, w_idx} < i_fill) && (r_addr[i_tok.row] == i_key);

    always_comb begin
        n_tok = i_tok;
        if (i_tok_valid && w_match && !i_tok.hit) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_idx   = w_idx;
            n_tok.hit_count = r_count[i_tok.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_wr.en && (i_wr.idx[IDX_W-1 -: CELL_W] == i_cell_id)) begin
            r_addr[i_wr.idx[ROW_W-1:0]]  <= i_wr.addr;
            r_count[i_wr.idx[ROW_W-1:0]] <= i_wr.count;
        end
    end

    assign o_tok_valid = r_vld;
    assign o_tok       = r_tok;

endmodule

`default_nettype wire

[rtl/arp_reply_solicitation_filter.sv]
// Top level: ARP reply filter, a chain of table cells searched row by row.
// A request or reply word is searched row by row down the cell chain, then the table is
// updated and the result issued; other words go straight to the result. One word is in
// flight at a time, so the next word is taken only after the result is issued; a result
// also waits in ST_RESULT while the previous output is still held by m_axis_tready.
// Reset (i_rst_n, synchronous, active low) empties the table at once via the fill mark.
`default_nettype none
`include "arp_reply_solicitation_filter_macros.svh"

module arp_reply_solicitation_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] ethertype, [31:16] arp_opcode, [47:32] arp_proto_type,
    // [79:48] sender_ip, [111:80] target_ip
    input  logic [111:0] s_axis_tdata,
    // [0] cmd (0 outbound, 1 inbound)
    input  logic [0:0]   s_axis_tuser,
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] drop, [1] tracked, [33:2] count_after, [34] table_full, [39:35] zero
    output logic [39:0]  m_axis_tdata
);
    import arsf_pkg::*;

    // Table layout: slot = cell * CELL_ROWS + row. Slots are filled in order and
    // never freed, so slots below r_fill are exactly the valid ones and the next
    // insert always goes to slot r_fill (the lowest free entry).
    // Each address lives in at most one slot, so any hit is the lowest hit.

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [IP_W-1:0]   r_key, n_key;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [ROW_W-1:0]  r_inj, n_inj;
    logic              r_inj_on, n_inj_on;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0]  r_hit_cnt, n_hit_cnt;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    t_write            w_wr;
    t_token            w_tok [NUM_CELLS+1];
    logic              w_vld [NUM_CELLS+1];
    logic              w_last;
    logic              w_accept;
    logic              w_ipv4_arp;
    logic [CNT_W-1:0]  w_cnt;

    // input word fields
    logic [15:0]       w_ethertype, w_opcode, w_proto;
    logic [IP_W-1:0]   w_sender, w_target;

    assign w_ethertype = s_axis_tdata[15:0];
    assign w_opcode    = s_axis_tdata[31:16];
    assign w_proto     = s_axis_tdata[47:32];
    assign w_sender    = s_axis_tdata[79:48];
    assign w_target    = s_axis_tdata[111:80];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_ipv4_arp    = (w_ethertype == ETHERTYPE_ARP) && (w_proto == ETHERTYPE_IPV4);

    // head of chain: one token per row while injecting
    assign w_vld[0]           = (r_state == ST_SCAN) && r_inj_on;
    assign w_tok[0].row       = r_inj;
    assign w_tok[0].hit       = 1'b0;
    assign w_tok[0].hit_idx   = '0;
    assign w_tok[0].hit_count = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        arsf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cell_id   (CELL_W'(g)),
            .i_key       (r_key),
            .i_fill      (r_fill),
            .i_wr        (w_wr),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    // last row token leaving the chain closes the search
    assign w_last = w_vld[NUM_CELLS] && (w_tok[NUM_CELLS].row == ROW_W'(CELL_ROWS - 1));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_fill      = r_fill;
        n_inj       = r_inj;
        n_inj_on    = r_inj_on;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_cnt   = r_hit_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_wr        = '0;
        w_cnt       = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_ipv4_arp && !s_axis_tuser[0] && (w_opcode == OPCODE_REQUEST)) begin
                        n_op = OP_REQUEST;
                    end else if (w_ipv4_arp && s_axis_tuser[0]
                                 && (w_opcode == OPCODE_REPLY)) begin
                        n_op = OP_REPLY;
                    end else begin
                        n_op = OP_NONE;
                    end
                    n_key = s_axis_tuser[0] ? w_sender : w_target;
                    if (n_op == OP_NONE) begin
                        n_res   = '0;
                        n_state = ST_RESULT;
                    end else begin
                        n_inj    = '0;
                        n_inj_on = 1'b1;
                        n_hit    = 1'b0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_inj_on) begin
                    n_inj = r_inj + 1'b1;
                    if (r_inj == ROW_W'(CELL_ROWS - 1)) begin
                        n_inj_on = 1'b0;
                    end
                end
                if (w_vld[NUM_CELLS] && w_tok[NUM_CELLS].hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = w_tok[NUM_CELLS].hit_idx;
                    n_hit_cnt = w_tok[NUM_CELLS].hit_count;
                end
                if (w_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_res = '0;
                case (r_op)
                    OP_REQUEST: begin
                        if (r_hit) begin
                            // saturating increment
                            w_cnt = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;
                            w_wr  = '{en: 1'b1, idx: r_hit_idx, addr: r_key, count: w_cnt};
                            n_res.tracked     = 1'b1;
                            n_res.count_after = w_cnt;
                        end else if (r_fill < FILL_W'(TABLE_ENTRIES)) begin
                            w_cnt  = CNT_W'(1);
                            w_wr   = '{en: 1'b1, idx: r_fill[IDX_W-1:0], addr: r_key,
                                       count: w_cnt};
                            n_fill = r_fill + 1'b1;
                            n_res.tracked     = 1'b1;
                            n_res.count_after = w_cnt;
                        end else begin
                            n_res.table_full = 1'b1;
                        end
                    end
                    OP_REPLY: begin
                        if (r_hit && (r_hit_cnt != '0)) begin
                            w_cnt = r_hit_cnt - 1'b1;
                            w_wr  = '{en: 1'b1, idx: r_hit_idx, addr: r_key, count: w_cnt};
                            n_res.tracked     = 1'b1;
                            n_res.count_after = w_cnt;
                        end else begin
                            // unsolicited: absent sender or no request outstanding
                            n_res.drop = 1'b1;
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_inj_on    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_inj_on    <= n_inj_on;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_inj     <= n_inj;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_hit_cnt <= n_hit_cnt;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.table_full, r_out.count_after,
                            r_out.tracked, r_out.drop};

    `ARSF_CHK(a_fill_bound, r_fill <= FILL_W'(TABLE_ENTRIES), "fill mark past table size")
    `ARSF_CHK(a_accept_busy, w_accept |=> (r_state != ST_IDLE), "accept did not start work")
    `ARSF_CHK(a_fill_on_update, !$stable(r_fill) |-> ($past(r_state) == ST_UPDATE),
              "fill mark moved outside update")
    `ARSF_CHK(a_result_flags, r_out_valid |-> !(r_out.tracked && (r_out.drop || r_out.table_full)),
              "tracked result also flagged drop or full")
    `ARSF_CHK(a_chain_drained, (r_state == ST_IDLE) |-> !w_vld[NUM_CELLS],
              "search token left in chain while idle")

endmodule

`default_nettype wire
